/* src/balt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// balt_pkg
// Shared types, constants and helpers of the barometric altitude smoother:
// control word of the microcoded sequencer, status flags and saturation.
// ----------------------------------------------------------------------------
package balt_pkg;

  // Raw sample fields and the bits of them that are used
  localparam int RAW_BITS = 24;
  localparam int RAW_W    = 24;
  localparam logic [RAW_W-1:0] RAW_MASK = RAW_W'((64'd1 << RAW_BITS) - 64'd1);

  // Pressure conversion: q16 = P_ZERO_Q16 - floor((raw*4456448 + 629999) / 900000).
  // With the common factor 32 taken out this is floor((raw*139264 + 19687) / 28125).
  // Split raw = a*28125 + b, so q = a*139264 + floor((b*139264 + 19687) / 28125);
  // both divisions by 28125 are a multiply by ceil(2^46 / 28125) and a shift by 46.
  localparam int DIV_Q_W   = 27;
  localparam int DIV_A_W   = 10;
  localparam int DIV_B_W   = 15;
  localparam int DIV_SHIFT = 46;
  localparam int DIV_CNT_W = 3;
  localparam logic [RAW_W-1:0] DIV_D      = 24'd28125;
  localparam logic [31:0]      DIV_RECIP  = 32'd2501999793;
  localparam logic [31:0]      DIV_BIAS   = 32'd19687;
  localparam logic [31:0]      P_ZERO_Q16 = 32'd89476301;

  // Divider phases, counted down from the start
  localparam logic [DIV_CNT_W-1:0] DIV_PH_MUL_R = 3'd6;
  localparam logic [DIV_CNT_W-1:0] DIV_PH_QUO_A = 3'd5;
  localparam logic [DIV_CNT_W-1:0] DIV_PH_REM   = 3'd4;
  localparam logic [DIV_CNT_W-1:0] DIV_PH_SCALE = 3'd3;
  localparam logic [DIV_CNT_W-1:0] DIV_PH_MUL_Y = 3'd2;
  localparam logic [DIV_CNT_W-1:0] DIV_PH_SUM   = 3'd1;

  // Shared multiplier
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  // Baseline settling
  localparam logic [3:0] SEEN_MAX = 4'd15;

  // Configuration register map
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP_COMP = 2'd0,
    CFG_WEIGHT    = 2'd1,
    CFG_SETTLE    = 2'd2
  } cfg_idx_t;

  // Microcode fields
  typedef logic [3:0] step_t;

  typedef enum logic [1:0] {
    MUL_NONE = 2'd0,
    MUL_TEMP = 2'd1,
    MUL_PRES = 2'd2,
    MUL_COMP = 2'd3
  } mul_op_t;

  typedef enum logic [1:0] {
    AVG_HOLD    = 2'd0,
    AVG_SEED    = 2'd1,
    AVG_BLEND_T = 2'd2,
    AVG_BLEND_P = 2'd3
  } avg_op_t;

  typedef enum logic [2:0] {
    JMP_NEXT     = 3'd0,
    JMP_DIV_BUSY = 3'd1,
    JMP_UNSEEDED = 3'd2,
    JMP_ALWAYS   = 3'd3,
    JMP_END      = 3'd4
  } jump_t;

  typedef struct packed {
    logic    div_start;
    logic    p_load;
    mul_op_t mul_op;
    avg_op_t avg_op;
    logic    count_en;
    logic    diff_en;
    logic    out_load;
    jump_t   jump;
    step_t   target;
  } ctrl_t;

  localparam ctrl_t CTRL_IDLE = ctrl_t'('0);

  typedef struct packed {
    logic div_busy;
    logic seeded;
    logic out_free;
  } stat_t;

  // Clamp a wide signed value to the 32-bit signed range
  function automatic logic [31:0] sat32(input logic signed [55:0] x);
    logic [31:0] r;
    if (x[55:31] == {25{x[55]}}) begin
      r = x[31:0];
    end else if (x[55]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7fff_ffff;
    end
    return r;
  endfunction

endpackage

/* src/balt_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// balt_div
// Pressure scaling divider: two reciprocal multiplications.
// ----------------------------------------------------------------------------
module balt_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [balt_pkg::RAW_W-1:0]   raw,
  output logic [balt_pkg::DIV_Q_W-1:0] quotient,
  output logic                         busy
);
  import balt_pkg::*;

  logic [DIV_CNT_W-1:0] cnt;
  logic [RAW_W-1:0]     r;
  logic [DIV_A_W-1:0]   a;
  logic [DIV_B_W-1:0]   b;
  logic [31:0]          y;
  logic [31:0]          mul_x;
  logic [63:0]          prod;
  logic [RAW_W-1:0]     a_d;
  logic [RAW_W-1:0]     r_less;

  // Multiplier operand: the raw count first, the scaled remainder second
  assign mul_x  = (cnt == DIV_PH_MUL_R) ? {{(32 - RAW_W){1'b0}}, r} : y;
  assign a_d    = {{(RAW_W - DIV_A_W){1'b0}}, a} * DIV_D;
  assign r_less = r - a_d;

  // Phase count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= DIV_PH_MUL_R;
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  // Split raw into a*28125 + b, scale b by 139264 (2^17 + 2^13), divide again
  // and add a*139264 back
  always_ff @(posedge clk) begin
    if (start) begin
      r <= raw;
    end
    if (cnt == DIV_PH_MUL_R || cnt == DIV_PH_MUL_Y) begin
      prod <= mul_x * DIV_RECIP;
    end
    if (cnt == DIV_PH_QUO_A) begin
      a <= prod[DIV_SHIFT+DIV_A_W-1:DIV_SHIFT];
    end
    if (cnt == DIV_PH_REM) begin
      b <= r_less[DIV_B_W-1:0];
    end
    if (cnt == DIV_PH_SCALE) begin
      y <= {b, 17'd0} + {4'd0, b, 13'd0} + DIV_BIAS;
    end
    if (cnt == DIV_PH_SUM) begin
      quotient <= {a, 17'd0} + {4'd0, a, 13'd0} +
                  {{(DIV_Q_W - (64 - DIV_SHIFT)){1'b0}}, prod[63:DIV_SHIFT]};
    end
  end

  assign busy = cnt != '0;

  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not start");

endmodule

/* src/balt_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// balt_seq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module balt_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_accept,
  input  balt_pkg::stat_t       stat,
  output balt_pkg::ctrl_t       ctrl,
  output logic                  running
);
  import balt_pkg::*;

  localparam step_t S_CONV    = 4'd0;
  localparam step_t S_DIV     = 4'd1;
  localparam step_t S_PCONV   = 4'd2;
  localparam step_t S_MUL_T   = 4'd3;
  localparam step_t S_BLEND_T = 4'd4;
  localparam step_t S_BLEND_P = 4'd5;
  localparam step_t S_SEED    = 4'd6;
  localparam step_t S_COUNT   = 4'd7;
  localparam step_t S_MUL_C   = 4'd8;
  localparam step_t S_DIFF    = 4'd9;
  localparam step_t S_OUT     = 4'd10;

  // Control store
  function automatic ctrl_t rom(input step_t s);
    ctrl_t w;
    w = CTRL_IDLE;
    unique case (s)
      S_CONV:    w.div_start = 1'b1;
      S_DIV: begin
        w.jump   = JMP_DIV_BUSY;
        w.target = S_DIV;
      end
      S_PCONV: begin
        w.p_load = 1'b1;
        w.jump   = JMP_UNSEEDED;
        w.target = S_SEED;
      end
      S_MUL_T:   w.mul_op = MUL_TEMP;
      S_BLEND_T: begin
        w.avg_op = AVG_BLEND_T;
        w.mul_op = MUL_PRES;
      end
      S_BLEND_P: begin
        w.avg_op = AVG_BLEND_P;
        w.jump   = JMP_ALWAYS;
        w.target = S_COUNT;
      end
      S_SEED:    w.avg_op = AVG_SEED;
      S_COUNT:   w.count_en = 1'b1;
      S_MUL_C:   w.mul_op = MUL_COMP;
      S_DIFF:    w.diff_en = 1'b1;
      S_OUT: begin
        w.out_load = 1'b1;
        w.jump     = JMP_END;
      end
      default:   w = CTRL_IDLE;
    endcase
    return w;
  endfunction

  step_t step, step_next;
  logic  running_next;

  assign ctrl = running ? rom(step) : CTRL_IDLE;

  // Next step selection
  always_comb begin
    step_next    = step;
    running_next = running;
    if (!running) begin
      if (s_accept) begin
        running_next = 1'b1;
        step_next    = S_CONV;
      end
    end else begin
      unique case (ctrl.jump)
        JMP_NEXT:     step_next = step + 4'd1;
        JMP_DIV_BUSY: step_next = stat.div_busy ? ctrl.target : step + 4'd1;
        JMP_UNSEEDED: step_next = stat.seeded ? step + 4'd1 : ctrl.target;
        JMP_ALWAYS:   step_next = ctrl.target;
        JMP_END:      running_next = !stat.out_free;
        default:      step_next = step;
      endcase
    end
  end

  // Hold step counter and run flag
  always_ff @(posedge clk) begin
    if (rst) begin
      step    <= S_CONV;
      running <= 1'b0;
    end else begin
      step    <= step_next;
      running <= running_next;
    end
  end

  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> running && step == S_CONV)
    else $error("program did not start on accepted beat");

  a_end_release: assert property (@(posedge clk) disable iff (rst)
    (running && ctrl.jump == JMP_END && stat.out_free) |=> !running)
    else $error("program did not finish after result load");

endmodule

/* src/balt_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// balt_dp
// Datapath: sample registers, shared multiplier, averages, baseline,
// difference and height, configuration registers and the result register.
// ----------------------------------------------------------------------------
module balt_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_accept,
  input  logic [47:0]                    s_tdata,
  input  logic                           cfg_valid,
  input  logic [balt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  input  balt_pkg::ctrl_t                ctrl,
  input  logic [balt_pkg::DIV_Q_W-1:0]   quotient,
  output logic [balt_pkg::RAW_W-1:0]     p_raw,
  output logic                           seeded,
  output logic                           out_free,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [95:0]                    m_tdata,
  output logic                           m_tuser
);
  import balt_pkg::*;

  // Configuration
  logic signed [31:0] temp_comp;
  logic [15:0]        weight;
  logic [3:0]         settle;

  // Sample and working registers
  logic [RAW_W-1:0]   raw_t, raw_p;
  logic [31:0]        xp;
  logic [31:0]        avg_t, avg_p, base_t, base_p;
  logic [3:0]         seen;
  logic               latched;
  logic signed [51:0] diff;
  logic signed [PROD_W-1:0] prod;

  // Combinational terms
  logic [31:0]              t_q8;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_rnd;
  logic [31:0]              blend_inc;
  logic signed [49:0]       comp;
  logic signed [32:0]       dp;
  logic [3:0]               seen_next, need;
  logic signed [55:0]       dx, h_pre, h;

  // Take config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_comp <= '0;
      weight    <= 16'd13107;
      settle    <= 4'd5;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TEMP_COMP: temp_comp <= cfg_data;
        CFG_WEIGHT:    weight    <= cfg_data[15:0];
        CFG_SETTLE:    settle    <= cfg_data[3:0];
        default:       ;
      endcase
    end
  end

  // Capture a sample beat
  always_ff @(posedge clk) begin
    if (s_accept) begin
      raw_t <= s_tdata[23:0] & RAW_MASK;
      raw_p <= s_tdata[47:24] & RAW_MASK;
    end
  end

  assign t_q8 = {raw_t, 8'd0};

  // Raw pressure, fed to the divider
  assign p_raw = raw_p;

  always_ff @(posedge clk) begin
    if (ctrl.p_load) begin
      xp <= P_ZERO_Q16 - {{(32 - DIV_Q_W){1'b0}}, quotient};
    end
  end

  // Shared multiplier operand select
  always_comb begin
    unique case (ctrl.mul_op)
      MUL_TEMP: begin
        mul_a = $signed({1'b0, t_q8} - {1'b0, avg_t});
        mul_b = $signed({17'd0, weight});
      end
      MUL_PRES: begin
        mul_a = $signed({1'b0, xp} - {1'b0, avg_p});
        mul_b = $signed({17'd0, weight});
      end
      MUL_COMP: begin
        mul_a = $signed({1'b0, avg_t} - {1'b0, base_t});
        mul_b = $signed({temp_comp[31], temp_comp});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Round at bit 15 and take the floor of the shift by 16
  assign prod_rnd  = prod + PROD_W'(32768);
  assign blend_inc = prod_rnd[47:16];
  assign comp      = prod_rnd[65:16];

  // Settling counter
  assign seen_next = (seen == SEEN_MAX) ? seen : seen + 4'd1;
  assign need      = (settle == 4'd0) ? 4'd1 : settle;

  // Averages, seed flag and baseline
  always_ff @(posedge clk) begin
    if (rst) begin
      avg_t   <= '0;
      avg_p   <= '0;
      base_t  <= '0;
      base_p  <= '0;
      seeded  <= 1'b0;
      seen    <= '0;
      latched <= 1'b0;
    end else begin
      unique case (ctrl.avg_op)
        AVG_SEED: begin
          avg_t  <= t_q8;
          avg_p  <= xp;
          seeded <= 1'b1;
        end
        AVG_BLEND_T: avg_t <= avg_t + blend_inc;
        AVG_BLEND_P: avg_p <= avg_p + blend_inc;
        default:     ;
      endcase
      if (ctrl.count_en) begin
        seen <= seen_next;
        if (!latched && seen_next >= need) begin
          base_t  <= avg_t;
          base_p  <= avg_p;
          latched <= 1'b1;
        end
      end
    end
  end

  // Compensated difference, zero until the baseline exists
  assign dp = $signed({1'b0, avg_p} - {1'b0, base_p});

  always_ff @(posedge clk) begin
    if (ctrl.diff_en) begin
      diff <= latched ? ({{19{dp[32]}}, dp} + {{2{comp[49]}}, comp}) : '0;
    end
  end

  // Height: floor((-10*diff + 128) / 256)
  assign dx    = {{4{diff[51]}}, diff};
  assign h_pre = 56'sd128 - ((dx <<< 3) + (dx <<< 1));
  assign h     = h_pre >>> 8;

  assign out_free = !m_tvalid || m_tready;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.out_load && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load && out_free) begin
      m_tdata <= {avg_t, sat32(dx), sat32(h)};
      m_tuser <= latched;
    end
  end

  a_pre_base_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> m_tdata[63:0] == 64'd0)
    else $error("nonzero difference before baseline");

  a_latch_after_seed: assert property (@(posedge clk) disable iff (rst)
    latched |-> seeded)
    else $error("baseline latched without seed");

endmodule

/* src/baro_altitude_smoother_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_altitude_smoother_core
// Smooths raw barometer samples and reports pressure and height change.
// ----------------------------------------------------------------------------
// Usage:
//   s_* takes one beat per sample pair: raw temperature and raw pressure.
//   m_* returns one beat per sample: height in 1/256 m, compensated pressure
//   change in 1/65536 hPa, averaged temperature (Q24.8), and in m_tuser the
//   baseline-ready flag. cfg_* writes temperature compensation (index 0),
//   smoothing weight (1) and settle count (2); write it only while idle.
//   A microcode program runs per sample: one start step, a wait on the
//   pressure divider (two reciprocal multiplications), then eight steps
//   on one shared multiplier (six on the seed sample, which skips the blends).
//   s_tready stays low for that whole program, so a new sample is taken only
//   once the previous one has finished its program.
//   The result register decouples the sides: a new sample is accepted while a
//   result waits; if it is still not taken when the next one is ready, the
//   program holds on its last step until m_tready.
//   Reset (rst, synchronous) clears the averages, baseline and counters and
//   restores the configuration defaults.
// ----------------------------------------------------------------------------
module baro_altitude_smoother_core (
  input  logic                           clk,
  input  logic                           rst,
  // Sample input
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [47:0]                    s_tdata,   // [23:0] raw_temperature, [47:24] raw_pressure
  // Result output
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [95:0]                    m_tdata,   // [31:0] height_estimate,
                                                    // [63:32] pressure_difference,
                                                    // [95:64] smoothed_temperature
  output logic                           m_tuser,   // [0] baseline_ready
  // Configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [balt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);
  import balt_pkg::*;

  ctrl_t              ctrl;
  stat_t              stat;
  logic               running;
  logic               s_accept;
  logic               div_busy;
  logic               seeded;
  logic               out_free;
  logic [RAW_W-1:0]   p_raw;
  logic [DIV_Q_W-1:0] quotient;

  assign s_tready  = !running;
  assign s_accept  = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign stat = '{div_busy: div_busy, seeded: seeded, out_free: out_free};

  balt_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .s_accept (s_accept),
    .stat     (stat),
    .ctrl     (ctrl),
    .running  (running)
  );

  balt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.div_start),
    .raw      (p_raw),
    .quotient (quotient),
    .busy     (div_busy)
  );

  balt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_accept  (s_accept),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctrl      (ctrl),
    .quotient  (quotient),
    .p_raw     (p_raw),
    .seeded    (seeded),
    .out_free  (out_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
